// ----- sv/ddo_pkg.sv -----
package ddo_pkg;

  typedef struct packed {
    logic signed [15:0] duty_left;
    logic signed [15:0] duty_right;
    logic [31:0]        stamp_us;
  } ddo_in_t;

  typedef struct packed {
    logic signed [31:0] speed_forward;
    logic signed [31:0] turn_rate;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [31:0]        heading;
    logic               pose_valid;
  } ddo_out_t;

  localparam logic [2:0] RegGainLeft   = 3'd0;
  localparam logic [2:0] RegGainRight  = 3'd1;
  localparam logic [2:0] RegRadiusLeft = 3'd2;
  localparam logic [2:0] RegRadiusRight = 3'd3;
  localparam logic [2:0] RegBaseline   = 3'd4;

  localparam logic signed [31:0] CordicStart  = 32'sd652032874;
  localparam logic [17:0]        BamPerRateUs = 18'd174993;
  localparam logic signed [31:0] StraightLim  = 32'sd6;
  localparam logic [19:0]        UsPerS       = 20'd1000000;
  // ceil(2^52 / 10^6): exact quotient for any 32-bit dividend
  localparam logic [32:0]        UsRecip      = 33'd4503599628;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,  // latch item, form radius-gain products
    OP_SPEED  = 4'd2,  // wheel surface speeds (rate dividend)
    OP_DIVST  = 4'd3,  // start a division (sel in cmd)
    OP_DIVRES = 4'd4,  // take divider result
    OP_HSTEP  = 4'd5,  // heading step product
    OP_CSTART = 4'd6,  // start CORDIC on angle
    OP_CSTEP  = 4'd7,
    OP_CTAKE  = 4'd8,
    OP_MUL    = 4'd9,  // position multiplies
    OP_ACC    = 4'd10, // update pose
    OP_FIRST  = 4'd11  // first item, stamp only
  } ddo_op_e;

  typedef struct packed {
    ddo_op_e    op;
    logic [1:0] sel;
  } ddo_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cordic_done;
    logic straight;
    logic have_last;
  } ddo_stat_t;

  localparam logic [1:0] SelRate  = 2'd0;
  localparam logic [1:0] SelDist  = 2'd1;
  localparam logic [1:0] SelRad   = 2'd2;
  localparam logic [1:0] SelNew   = 2'd1;
  localparam logic [1:0] SelOld   = 2'd0;

  function automatic logic [31:0] atan_bam(input logic [4:0] k);
    logic [31:0] r;
    unique case (k)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;       5'd21: r = 32'd326;
      5'd22: r = 32'd163;       5'd23: r = 32'd81;
      5'd24: r = 32'd41;        5'd25: r = 32'd20;
      5'd26: r = 32'd10;        5'd27: r = 32'd5;
      5'd28: r = 32'd3;         5'd29: r = 32'd1;
      5'd30: r = 32'd1;         default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ----- sv/diff_drive_odometry_core.sv -----
// Differential-drive odometry core.
// Input channel (in_valid_i/in_stall_o, in_data_i): left/right duty, stamp.
// Output channel (out_valid_o/out_stall_i, out_data_o): speeds and pose.
// A transfer happens at a clock edge with valid high and stall low.
// Each item runs through a controller and a shared datapath: a 64-step
// serial division for the turn rate, then either a divide by 10^6 in 12-bit
// digits for the straight distance or a second 64-step division for the arc
// radius, and one or two CORDIC passes of CORDIC_STEPS micro-rotations.
// The first item runs only the turn-rate division and stores its stamp;
// the serial divisions and CORDIC passes set the time from input
// transfer to result valid.
// One item at a time: the next input transfer comes only once the result
// has been taken by the receiver.
// While the receiver stalls the result holds and input stays stalled.
// Reset clears pose, heading and stored stamp; registers return defaults.
// Registers via APB at byte address 4*i; pready always high.
module diff_drive_odometry_core import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ddo_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ddo_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [15:0] gl_q, gr_q, rl_q, rr_q, bl_q;
  logic        wr;
  ddo_cmd_t    cmd;
  ddo_stat_t   stat;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gl_q <= 16'd6400; gr_q <= 16'd6400;
      rl_q <= 16'd1311; rr_q <= 16'd1311; bl_q <= 16'd6554;
    end else if (wr && paddr[1:0] == 2'd0) begin
      unique case (paddr[4:2])
        RegGainLeft:    gl_q <= pwdata[15:0];
        RegGainRight:   gr_q <= pwdata[15:0];
        RegRadiusLeft:  rl_q <= pwdata[15:0];
        RegRadiusRight: rr_q <= pwdata[15:0];
        RegBaseline:    bl_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegGainLeft:    prdata = {16'd0, gl_q};
      RegGainRight:   prdata = {16'd0, gr_q};
      RegRadiusLeft:  prdata = {16'd0, rl_q};
      RegRadiusRight: prdata = {16'd0, rr_q};
      RegBaseline:    prdata = {16'd0, bl_q};
      default:        prdata = '0;
    endcase
  end

  ddo_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  ddo_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i(in_data_i),
    .gain_left_i(gl_q), .gain_right_i(gr_q), .radius_left_i(rl_q),
    .radius_right_i(rr_q), .baseline_i(bl_q), .stat_o(stat), .result_o(out_data_o)
  );
endmodule

// ----- sv/ddo_div.sv -----
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
module ddo_div import ddo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [63:0] den_i,
  output logic               done_o,
  output logic signed [63:0] quo_o
);
  logic [63:0] q_q, q_d, r_q, r_d, d_q, d_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d;
  logic [64:0] trial;
  logic [63:0] rs;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    q_d    = q_q;
    r_d    = r_q;
    d_d    = d_q;
    neg_d  = neg_q;
    rs     = {r_q[62:0], q_q[63]};
    trial  = {1'b0, rs} - {1'b0, d_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 7'd0;
      q_d    = num_i[63] ? 64'(-num_i) : 64'(num_i);
      d_d    = den_i[63] ? 64'(-den_i) : 64'(den_i);
      r_d    = '0;
      neg_d  = num_i[63] ^ den_i[63];
    end else if (busy_q) begin
      if (!trial[64]) begin
        r_d = trial[63:0];
        q_d = {q_q[62:0], 1'b1};
      end else begin
        r_d = rs;
        q_d = {q_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    r_q   <= r_d;
    d_q   <= d_d;
    neg_q <= neg_d;
  end

  assign done_o = !busy_q && !start_i;
  assign quo_o  = neg_q ? 64'(-q_q) : 64'(q_q);
endmodule

// ----- sv/ddo_cordic.sv -----
// Rotation-mode CORDIC, one micro-rotation per cycle, Q4.30 sine and cosine.
module ddo_cordic import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        angle_i,
  output logic               done_o,
  output logic signed [33:0] sin_o,
  output logic signed [33:0] cos_o
);
  localparam int unsigned CntW = $clog2(CORDIC_STEPS + 1);

  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [32:0] z_q, z_d;
  logic               flip_q, flip_d, busy_q, busy_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [4:0]         k;
  logic [31:0]        a;
  logic signed [33:0] xs, ys;
  logic signed [32:0] at;

  assign k  = cnt_q[4:0];
  assign xs = x_q >>> k;
  assign ys = y_q >>> k;
  assign at = {1'b0, atan_bam(k)};

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    flip_d = flip_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    a      = angle_i;
    if (start_i) begin
      flip_d = (angle_i[31:30] == 2'd1) || (angle_i[31:30] == 2'd2);
      if (flip_d) a = angle_i + 32'h80000000;
      z_d    = {a[31], a};
      x_d    = 34'(CordicStart);
      y_d    = '0;
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(CORDIC_STEPS - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
  end

  assign done_o = !busy_q && !start_i;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;
endmodule

// ----- sv/ddo_datapath.sv -----
module ddo_datapath import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ddo_cmd_t    cmd_i,
  input  ddo_in_t     item_i,
  input  logic [15:0] gain_left_i,
  input  logic [15:0] gain_right_i,
  input  logic [15:0] radius_left_i,
  input  logic [15:0] radius_right_i,
  input  logic [15:0] baseline_i,
  output ddo_stat_t   stat_o,
  output ddo_out_t    result_o
);
  ddo_in_t            item_q;
  logic signed [63:0] sl_q, sr_q;
  logic [31:0]        rl_q, rr_q;
  logic signed [31:0] speed_q, rate_q, dist_q, rad_q, px_q, py_q;
  logic [31:0]        head_q, h1_q, last_q, dt_q;
  logic               have_q, valid_q;
  logic signed [63:0] wb_q, pa_q, pb_q;
  logic signed [33:0] s0_q, c0_q;
  logic signed [63:0] num, den, quo, sum;
  logic               div_start, div_done, c_start, c_done;
  logic signed [33:0] c_sin, c_cos;
  logic [63:0]        hlo_q, hsum;
  logic [31:0]        hhi_q;
  logic [15:0]        base;
  // divide-by-10^6 unit: 12-bit digits, reciprocal multiply then remainder
  logic [71:0]        cd_sh_q;
  logic [19:0]        cd_rem_q;
  logic [63:0]        cd_quo_q;
  logic [11:0]        cd_dig_q;
  logic [3:0]         cd_cnt_q;
  logic               cd_busy_q, cd_neg_q, cd_start, cd_done;
  logic [31:0]        cd_x, cd_rem;
  logic [64:0]        cd_prod;
  logic [63:0]        cd_mag;
  logic signed [63:0] cd_quo;

  assign base = (baseline_i == 16'd0) ? 16'd1 : baseline_i;
  assign sum  = sr_q + sl_q;

  always_comb begin
    unique case (cmd_i.sel)
      SelRate: begin num = sr_q - sl_q; den = 64'({base, 7'd0}); end
      SelDist: begin num = 64'(speed_q) * 64'(dt_q); den = 64'(UsPerS); end
      default: begin num = 64'(speed_q) <<< 16; den = 64'(rate_q); end
    endcase
  end
  assign div_start = (cmd_i.op == OP_DIVST) && (cmd_i.sel != SelDist);
  assign cd_start  = (cmd_i.op == OP_DIVST) && (cmd_i.sel == SelDist);
  assign c_start   = (cmd_i.op == OP_CSTART);
  assign hsum      = hlo_q + {hhi_q, 32'd0};

  assign cd_mag  = num[63] ? 64'(-num) : 64'(num);
  assign cd_x    = {cd_rem_q, cd_sh_q[71:60]};
  assign cd_prod = 65'(cd_x) * 65'(UsRecip);
  assign cd_rem  = cd_x - 32'(cd_dig_q) * 32'(UsPerS);
  assign cd_done = !cd_busy_q && !cd_start;
  assign cd_quo  = cd_neg_q ? -$signed(cd_quo_q) : $signed(cd_quo_q);

  ddo_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(den),
    .done_o(div_done), .quo_o(quo)
  );

  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(c_start),
    .angle_i((cmd_i.sel == SelNew) ? h1_q : head_q),
    .done_o(c_done), .sin_o(c_sin), .cos_o(c_cos)
  );

  // even count: quotient digit, odd count: remainder and shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_busy_q <= 1'b0;
      cd_cnt_q  <= '0;
    end else if (cd_start) begin
      cd_busy_q <= 1'b1;
      cd_cnt_q  <= '0;
    end else if (cd_busy_q) begin
      cd_cnt_q <= cd_cnt_q + 4'd1;
      if (cd_cnt_q == 4'd11) cd_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cd_start) begin
      cd_sh_q  <= {8'd0, cd_mag};
      cd_rem_q <= '0;
      cd_quo_q <= '0;
      cd_neg_q <= num[63];
    end else if (cd_busy_q) begin
      if (!cd_cnt_q[0]) begin
        cd_dig_q <= cd_prod[63:52];
      end else begin
        cd_rem_q <= cd_rem[19:0];
        cd_quo_q <= {cd_quo_q[51:0], cd_dig_q};
        cd_sh_q  <= {cd_sh_q[59:0], 12'd0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0; py_q <= '0; head_q <= '0; last_q <= '0;
      have_q <= 1'b0; valid_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OP_FIRST: begin
          last_q <= item_q.stamp_us; have_q <= 1'b1; valid_q <= 1'b0;
        end
        OP_ACC: begin
          px_q <= sat32(64'(px_q) + (pa_q >>> 30));
          py_q <= sat32(64'(py_q) + (pb_q >>> 30));
          head_q <= h1_q; last_q <= item_q.stamp_us; valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        item_q <= item_i;
        rl_q <= 32'(radius_left_i) * 32'(gain_left_i);
        rr_q <= 32'(radius_right_i) * 32'(gain_right_i);
      end
      OP_SPEED: begin
        sl_q <= 64'($signed({1'b0, rl_q})) * 64'(item_q.duty_left);
        sr_q <= 64'($signed({1'b0, rr_q})) * 64'(item_q.duty_right);
      end
      OP_DIVST: begin
        speed_q <= sat32(sum >>> 24);
        dt_q    <= item_q.stamp_us - last_q;
      end
      OP_DIVRES: begin
        unique case (cmd_i.sel)
          SelRate: begin rate_q <= sat32(quo); wb_q <= 64'(sat32(quo)) * 64'(BamPerRateUs); end
          SelDist: dist_q <= sat32(cd_quo);
          default: rad_q <= sat32(quo);
        endcase
      end
      // heading step mod 2^64 from two 32 x 32 partial products
      OP_HSTEP: begin
        hlo_q <= 64'(wb_q[31:0]) * 64'(dt_q);
        hhi_q <= wb_q[63:32] * dt_q;
      end
      OP_CSTART: if (cmd_i.sel == SelOld) h1_q <= head_q + hsum[55:24];
      OP_CTAKE: begin s0_q <= c_sin; c0_q <= c_cos; end
      OP_MUL: begin
        if (stat_o.straight) begin
          pa_q <= 64'(dist_q) * 64'(c0_q);
          pb_q <= 64'(dist_q) * 64'(s0_q);
        end else begin
          pa_q <= 64'(rad_q) * 64'(c_sin - s0_q);
          pb_q <= 64'(rad_q) * 64'(c0_q - c_cos);
        end
      end
      default: ;
    endcase
  end

  assign stat_o.div_done    = div_done && cd_done;
  assign stat_o.cordic_done = c_done;
  assign stat_o.straight    = (rate_q >= -StraightLim) && (rate_q <= StraightLim);
  assign stat_o.have_last   = have_q;

  assign result_o.speed_forward = speed_q;
  assign result_o.turn_rate     = rate_q;
  assign result_o.pose_x        = px_q;
  assign result_o.pose_y        = py_q;
  assign result_o.heading       = head_q;
  assign result_o.pose_valid    = valid_q;
endmodule

// ----- sv/ddo_ctrl.sv -----
module ddo_ctrl import ddo_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  ddo_stat_t stat_i,
  output ddo_cmd_t  cmd_o
);
  typedef enum logic [11:0] {
    S_IDLE  = 12'h001, S_SPEED = 12'h002, S_RDIV = 12'h004, S_RWAIT = 12'h008,
    S_BR    = 12'h010, S_HST   = 12'h020, S_C0   = 12'h040, S_C0W   = 12'h080,
    S_DDIV  = 12'h100, S_DWAIT = 12'h200, S_C1W  = 12'h400, S_ACC   = 12'h800
  } state_e;

  state_e     state_q, state_d;
  logic       ovalid_q, ovalid_d, div_rad_q, div_rad_d;
  logic       accept;

  // a new item is taken once the previous result has left
  assign in_stall_o  = (state_q != S_IDLE) || ovalid_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d   = state_q;
    ovalid_d  = ovalid_q && out_stall_i;
    div_rad_d = div_rad_q;
    cmd_o     = '{op: OP_NONE, sel: SelRate};
    unique case (state_q)
      S_IDLE:  if (accept) begin cmd_o.op = OP_LOAD; state_d = S_SPEED; end
      S_SPEED: begin cmd_o.op = OP_SPEED; state_d = S_RDIV; end
      S_RDIV:  begin cmd_o = '{op: OP_DIVST, sel: SelRate}; state_d = S_RWAIT; end
      S_RWAIT: if (stat_i.div_done) begin
        cmd_o = '{op: OP_DIVRES, sel: SelRate}; state_d = S_BR;
      end
      S_BR: if (stat_i.have_last) begin
        cmd_o.op = OP_HSTEP; state_d = S_HST;
      end else begin
        cmd_o.op = OP_FIRST; ovalid_d = 1'b1; state_d = S_IDLE;
      end
      S_HST: begin cmd_o = '{op: OP_CSTART, sel: SelOld}; state_d = S_C0; end
      S_C0:  state_d = S_C0W;
      S_C0W: if (stat_i.cordic_done) begin
        cmd_o.op = OP_CTAKE; state_d = S_DDIV;
      end
      S_DDIV: begin
        div_rad_d = !stat_i.straight;
        cmd_o = '{op: OP_DIVST, sel: stat_i.straight ? SelDist : SelRad};
        state_d = S_DWAIT;
      end
      S_DWAIT: if (stat_i.div_done) begin
        cmd_o = '{op: OP_DIVRES, sel: div_rad_q ? SelRad : SelDist};
        if (div_rad_q) state_d = S_C1W;
        else begin cmd_o.op = OP_DIVRES; state_d = S_C1W; end
      end
      S_C1W: begin
        if (div_rad_q) begin
          // second CORDIC pass on the new heading
          cmd_o = '{op: OP_CSTART, sel: SelNew};
          div_rad_d = 1'b0;
        end else if (stat_i.cordic_done) begin
          cmd_o = '{op: OP_MUL, sel: SelNew};
          state_d = S_ACC;
        end
      end
      S_ACC: begin cmd_o.op = OP_ACC; ovalid_d = 1'b1; state_d = S_IDLE; end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ovalid_q <= 1'b0; div_rad_q <= 1'b0;
    end else begin
      state_q <= state_d; ovalid_q <= ovalid_d; div_rad_q <= div_rad_d;
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_SPEED) else $error("accept lost");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("input open while busy");
`endif
endmodule
